>>> src/swgr_pkg.sv
// Shared types, constants and helper functions for the swipe gesture recognizer.
`default_nettype none

package swgr_pkg;

	// Field widths fixed by the stream and register formats.
	localparam int POS_W     = 12;
	localparam int KIND_W    = 3;
	localparam int VERDICT_W = 2;
	localparam int ANGLE_W   = 16;
	localparam int DIST_W    = 12;
	localparam int TIME_W    = 16;
	localparam int IN_DATA_W = ((2 * POS_W + 7) / 8) * 8;

	// Register port geometry.
	localparam int ADDR_W  = 3;
	localparam int PDATA_W = 32;

	// Algorithm constants.
	localparam int COORD_BITS      = 12;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int CORDIC_ITERS    = 16;
	localparam int ACC_FRAC        = 20;
	localparam int ATAN_LEN        = 24;

	// Derived datapath widths.
	localparam int PX_W   = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
	localparam int D_W    = PX_W + 1;
	localparam int CMP_W  = ((PX_W > DIST_W) ? PX_W : DIST_W) + 2;
	localparam int XY_W   = PX_W + 4 + ACC_FRAC;
	localparam int Z_W    = 31;
	localparam int ITER_W = $clog2(CORDIC_ITERS);
	localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int RND_W  = 10 + ANGLE_FRAC_BITS;

	localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(64'd180 << ACC_FRAC);
	localparam logic signed [Z_W-1:0] Z_FULL_TURN = Z_W'(64'd360 << ACC_FRAC);
	localparam logic [Z_W:0]          ROUND_HALF  = (Z_W + 1)'(64'd1 << (RND_SH - 1));
	localparam logic [RND_W-1:0]      ANGLE_LIM   = RND_W'(64'd360 << ANGLE_FRAC_BITS);
	localparam logic [ITER_W-1:0]     ITER_LAST   = ITER_W'(CORDIC_ITERS - 1);

	localparam logic [TIME_W-1:0] ELAPSED_MAX       = '1;
	localparam logic [DIST_W-1:0] MIN_DISTANCE_RST  = DIST_W'(20);
	localparam logic [TIME_W-1:0] TIMEOUT_RST       = TIME_W'(500);

	// Register selector, taken from address bit 2.
	localparam logic REG_MIN_DISTANCE = 1'b0;
	localparam logic REG_TIMEOUT      = 1'b1;

	// Pointer event kinds.
	localparam logic [KIND_W-1:0] REQ_PRESS   = 3'd0;
	localparam logic [KIND_W-1:0] REQ_MOVE    = 3'd1;
	localparam logic [KIND_W-1:0] REQ_DCLICK  = 3'd2;
	localparam logic [KIND_W-1:0] REQ_RELEASE = 3'd3;
	localparam logic [KIND_W-1:0] REQ_TICK    = 3'd4;

	// Result verdicts.
	localparam logic [VERDICT_W-1:0] VERDICT_IGNORE = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_MAYBE  = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_CANCEL = 2'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_FINISH = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              capture;
		logic              decide;
		logic              iter;
		logic              wrap;
		logic              round;
		logic              load_out;
		logic [ITER_W-1:0] iter_idx;
	} swgr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic has_result;
		logic go_cordic;
		logic out_free;
	} swgr_stat_t;

	// atan(2^-i) in units of 2^-20 degree, rounded to nearest.
	function automatic logic signed [Z_W-1:0] atan_step(input logic [4:0] idx);
		logic signed [Z_W-1:0] v;
		unique case (idx)
			5'd0:    v = Z_W'(47185920);
			5'd1:    v = Z_W'(27855475);
			5'd2:    v = Z_W'(14718068);
			5'd3:    v = Z_W'(7471121);
			5'd4:    v = Z_W'(3750058);
			5'd5:    v = Z_W'(1876857);
			5'd6:    v = Z_W'(938658);
			5'd7:    v = Z_W'(469357);
			5'd8:    v = Z_W'(234682);
			5'd9:    v = Z_W'(117342);
			5'd10:   v = Z_W'(58671);
			5'd11:   v = Z_W'(29335);
			5'd12:   v = Z_W'(14668);
			5'd13:   v = Z_W'(7334);
			5'd14:   v = Z_W'(3667);
			5'd15:   v = Z_W'(1833);
			5'd16:   v = Z_W'(917);
			5'd17:   v = Z_W'(458);
			5'd18:   v = Z_W'(229);
			5'd19:   v = Z_W'(115);
			5'd20:   v = Z_W'(57);
			5'd21:   v = Z_W'(29);
			5'd22:   v = Z_W'(14);
			5'd23:   v = Z_W'(7);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> src/swgr_regs.sv
// Configuration register file with its register-bus port.
`default_nettype none

module swgr_regs
	import swgr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output logic      [DIST_W-1:0]  min_distance,
	output logic      [TIME_W-1:0]  timeout_ms
);

	logic               wr_en;
	logic [DIST_W-1:0]  min_distance_q;
	logic [TIME_W-1:0]  timeout_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_distance_q <= MIN_DISTANCE_RST;
			timeout_q      <= TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MIN_DISTANCE: min_distance_q <= pwdata[DIST_W-1:0];
				REG_TIMEOUT:      timeout_q      <= pwdata[TIME_W-1:0];
				default:          min_distance_q <= min_distance_q;
			endcase
		end
	end

	// Read data is a plain mux of the registers.
	always_comb begin
		unique case (paddr[2])
			REG_MIN_DISTANCE: prdata = PDATA_W'(min_distance_q);
			REG_TIMEOUT:      prdata = PDATA_W'(timeout_q);
			default:          prdata = '0;
		endcase
	end

	assign min_distance = min_distance_q;
	assign timeout_ms   = timeout_q;

endmodule

`default_nettype wire

>>> src/swgr_ctrl.sv
// Controller state machine that sequences event handling and the CORDIC iterations.
`default_nettype none

module swgr_ctrl
	import swgr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire swgr_stat_t stat,
	output swgr_cmd_t       cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_ITER   = 6'b000100,
		S_WRAP   = 6'b001000,
		S_ROUND  = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [ITER_W-1:0] iter_q, iter_d;

	// Next state and command decode.
	always_comb begin
		state_d      = state_q;
		iter_d       = iter_q;
		s_tready     = 1'b0;
		cmd          = '0;
		cmd.iter_idx = iter_q;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				iter_d     = '0;
				if (stat.go_cordic) begin
					state_d = S_ITER;
				end else if (stat.has_result) begin
					state_d = S_OUT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ITER: begin
				cmd.iter = 1'b1;
				iter_d   = iter_q + 1'b1;
				if (iter_q == ITER_LAST) begin
					state_d = S_WRAP;
				end
			end
			S_WRAP: begin
				cmd.wrap = 1'b1;
				state_d  = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
		end
	end

endmodule

`default_nettype wire

>>> src/swgr_datapath.sv
// Datapath: press state, release checks, CORDIC vectoring unit and result register.
`default_nettype none

module swgr_datapath
	import swgr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire swgr_cmd_t            cmd,
	output swgr_stat_t                stat,
	input  wire logic [KIND_W-1:0]    in_kind,
	input  wire logic [POS_W-1:0]     in_x,
	input  wire logic [POS_W-1:0]     in_y,
	input  wire logic [DIST_W-1:0]    min_distance,
	input  wire logic [TIME_W-1:0]    timeout_ms,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [ANGLE_W-1:0]   m_tdata,
	output logic      [VERDICT_W-1:0] m_tuser
);

	// Captured event and press state.
	logic [KIND_W-1:0]  kind_q;
	logic [PX_W-1:0]    ev_x_q, ev_y_q;
	logic [PX_W-1:0]    start_x_q, start_y_q;
	logic [TIME_W-1:0]  elapsed_q;

	// CORDIC registers.
	logic signed [XY_W-1:0] cx_q, cy_q;
	logic signed [Z_W-1:0]  cz_q;

	// Pending result and output register.
	logic [VERDICT_W-1:0] res_verdict_q;
	logic [RND_W-1:0]     res_angle_q;
	logic                 out_valid_q;
	logic [ANGLE_W-1:0]   out_angle_q;
	logic [VERDICT_W-1:0] out_verdict_q;

	logic signed [D_W-1:0]   dx, yu, dx_abs, yu_turn;
	logic signed [CMP_W-1:0] dx_c, yu_c, min_c;
	logic                    near, too_late, cancel;
	logic signed [XY_W-1:0]  x_init, y_init, xs, ys;
	logic signed [Z_W-1:0]   atan_v;
	logic [Z_W:0]            rnd_sum;
	logic [RND_W-1:0]        angle_fin;

	// Release checks: travel from the press point and elapsed time.
	always_comb begin
		dx       = $signed({1'b0, ev_x_q}) - $signed({1'b0, start_x_q});
		yu       = $signed({1'b0, start_y_q}) - $signed({1'b0, ev_y_q});
		dx_c     = CMP_W'(dx);
		yu_c     = CMP_W'(yu);
		min_c    = $signed(CMP_W'(min_distance));
		near     = (dx_c < min_c) && (dx_c > -min_c) && (yu_c < min_c) && (yu_c > -min_c);
		too_late = elapsed_q > timeout_ms;
		cancel   = near || too_late;
	end

	// Status toward the controller.
	always_comb begin
		stat.has_result = (kind_q == REQ_PRESS) || (kind_q == REQ_MOVE) ||
		                  (kind_q == REQ_DCLICK) || (kind_q == REQ_RELEASE);
		stat.go_cordic  = (kind_q == REQ_RELEASE) && !cancel;
		stat.out_free   = !out_valid_q || m_tready;
	end

	// Vector start: a left-pointing vector is turned by a half turn first.
	always_comb begin
		dx_abs  = dx[D_W-1] ? -dx : dx;
		yu_turn = dx[D_W-1] ? -yu : yu;
		x_init  = $signed({{(XY_W - D_W - ACC_FRAC){dx_abs[D_W-1]}}, dx_abs,
		                   {ACC_FRAC{1'b0}}});
		y_init  = $signed({{(XY_W - D_W - ACC_FRAC){yu_turn[D_W-1]}}, yu_turn,
		                   {ACC_FRAC{1'b0}}});
	end

	// One vectoring step per cycle; shifts round toward minus infinity.
	always_comb begin
		xs      = cx_q >>> cmd.iter_idx;
		ys      = cy_q >>> cmd.iter_idx;
		atan_v  = atan_step(5'(cmd.iter_idx));
		rnd_sum = (Z_W + 1)'($unsigned(cz_q)) + ROUND_HALF;
	end

	// A full turn after rounding wraps back to zero.
	assign angle_fin = (res_angle_q >= ANGLE_LIM) ? (res_angle_q - ANGLE_LIM) : res_angle_q;

	// Event capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			ev_x_q <= in_x[PX_W-1:0];
			ev_y_q <= in_y[PX_W-1:0];
		end
	end

	// Press point and elapsed time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			elapsed_q <= ELAPSED_MAX;
		end else if (cmd.decide) begin
			unique case (kind_q)
				REQ_PRESS: begin
					start_x_q <= ev_x_q;
					start_y_q <= ev_y_q;
					elapsed_q <= '0;
				end
				REQ_DCLICK, REQ_RELEASE: begin
					start_x_q <= '0;
					start_y_q <= '0;
					elapsed_q <= ELAPSED_MAX;
				end
				REQ_TICK: begin
					if (elapsed_q != ELAPSED_MAX) begin
						elapsed_q <= elapsed_q + 1'b1;
					end
				end
				default: begin
					elapsed_q <= elapsed_q;
				end
			endcase
		end
	end

	// CORDIC unit and pending result.
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			cx_q        <= x_init;
			cy_q        <= y_init;
			cz_q        <= dx[D_W-1] ? Z_HALF_TURN : '0;
			res_angle_q <= '0;
			unique case (kind_q)
				REQ_PRESS:   res_verdict_q <= VERDICT_MAYBE;
				REQ_DCLICK:  res_verdict_q <= VERDICT_CANCEL;
				REQ_RELEASE: res_verdict_q <= cancel ? VERDICT_CANCEL : VERDICT_FINISH;
				default:     res_verdict_q <= VERDICT_IGNORE;
			endcase
		end
		if (cmd.iter) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + atan_v;
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - atan_v;
			end
		end
		if (cmd.wrap && cz_q[Z_W-1]) begin
			cz_q <= cz_q + Z_FULL_TURN;
		end
		if (cmd.round) begin
			res_angle_q <= rnd_sum[RND_SH +: RND_W];
		end
	end

	// Output register: holds a result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_angle_q   <= ANGLE_W'(angle_fin);
			out_verdict_q <= res_verdict_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_angle_q;
	assign m_tuser  = out_verdict_q;

endmodule

`default_nettype wire

>>> src/swipe_gesture_recognizer_core.sv
// Top level of the swipe gesture recognizer: stream ports, register port and submodules.
`default_nettype none

// Pointer events enter on the slave stream (kind in tuser, position in tdata) and each
// press, move, double click or release yields one transaction on the master stream;
// ticks and unknown kinds yield none. An event is taken in the idle state and decided in
// the next cycle. A press, move, double click or rejected release then loads the output
// register. A tick or an unknown kind returns straight to idle after the decision. An
// accepted release runs the shared CORDIC add/shift unit once per iteration for
// CORDIC_ITERS iterations, followed by a wrap step and a rounding step. A result waits in
// the output register while the next event is already accepted; the block stalls its
// input while an event is in flight, and also when a new result meets a full output
// register. Write the configuration registers only while no event is in flight.
module swipe_gesture_recognizer_core
	import swgr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Event input.
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,  // pos_x [11:0], pos_y [23:12]
	input  wire logic [KIND_W-1:0]    s_tuser,  // req_type [2:0]
	// Result output.
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [ANGLE_W-1:0]   m_tdata,  // swipe_angle [15:0]
	output logic      [VERDICT_W-1:0] m_tuser,  // verdict [1:0]
	// Configuration port.
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [PDATA_W-1:0]   pwdata,
	output logic      [PDATA_W-1:0]   prdata,
	output logic                      pready
);

	swgr_cmd_t          cmd;
	swgr_stat_t         stat;
	logic [DIST_W-1:0]  min_distance;
	logic [TIME_W-1:0]  timeout_ms;

	swgr_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.min_distance (min_distance),
		.timeout_ms   (timeout_ms)
	);

	swgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	swgr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_kind      (s_tuser),
		.in_x         (s_tdata[POS_W-1:0]),
		.in_y         (s_tdata[2*POS_W-1:POS_W]),
		.min_distance (min_distance),
		.timeout_ms   (timeout_ms),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule

`default_nettype wire
